@@ hdl/lcf_pkg.sv @@
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types, color slot codes, opcodes and preset color tables for the
// RGB555 light color fader.
// ----------------------------------------------------------------------------
package lcf_pkg;

    // One 5-bit channel and one packed RGB555 color (red 4:0, green 9:5,
    // blue 14:10).
    localparam int CHAN_W     = 5;
    localparam int NUM_CHANS  = 3;
    localparam int NUM_COLORS = 6;

    typedef logic [CHAN_W-1:0]           t_chan;
    typedef logic [NUM_CHANS*CHAN_W-1:0] t_color;
    typedef logic [2:0]                  t_scene;
    typedef logic [1:0]                  t_light;
    typedef logic [2:0]                  t_slot;

    // Color slots, in the order the colors are stored and reported.
    localparam t_slot COL_LIGHT0   = 3'd0;
    localparam t_slot COL_LIGHT1   = 3'd1;
    localparam t_slot COL_DIFFUSE  = 3'd2;
    localparam t_slot COL_AMBIENT  = 3'd3;
    localparam t_slot COL_SPECULAR = 3'd4;
    localparam t_slot COL_EMISSION = 3'd5;

    // Item opcodes.
    typedef enum logic [1:0] {
        OP_TICK       = 2'd0,
        OP_SET        = 2'd1,
        OP_FADE_SCENE = 2'd2,
        OP_FADE_LIGHT = 2'd3
    } t_opcode;

    // Packs three channel values into one RGB555 color.
    function automatic t_color rgb555(input int r, input int g, input int b);
        return {CHAN_W'(b), CHAN_W'(g), CHAN_W'(r)};
    endfunction

    // Light zero preset of a scene; scenes six and seven read as scene five.
    function automatic t_color scene_light0(input t_scene scene);
        t_color c;
        case (scene)
            3'd0:    c = rgb555(23, 23, 25);
            3'd1:    c = rgb555(10, 10, 16);
            3'd2:    c = rgb555(8, 8, 12);
            3'd3:    c = rgb555(5, 5, 8);
            3'd4:    c = rgb555(3, 3, 7);
            default: c = rgb555(0, 0, 6);
        endcase
        return c;
    endfunction

    // Ambient preset of a scene.
    function automatic t_color scene_ambient(input t_scene scene);
        t_color c;
        case (scene)
            3'd0, 3'd1, 3'd2: c = rgb555(14, 14, 14);
            3'd3:             c = rgb555(13, 13, 14);
            3'd4:             c = rgb555(10, 10, 12);
            default:          c = rgb555(8, 8, 10);
        endcase
        return c;
    endfunction

    // Emission preset of a scene.
    function automatic t_color scene_emission(input t_scene scene);
        t_color c;
        case (scene)
            3'd0, 3'd1, 3'd2, 3'd3: c = rgb555(16, 16, 16);
            3'd4:                   c = rgb555(14, 14, 16);
            default:                c = rgb555(12, 12, 16);
        endcase
        return c;
    endfunction

    // Scene preset for any slot but light one.
    function automatic t_color scene_color(input t_scene scene, input t_slot slot);
        t_color c;
        case (slot)
            COL_LIGHT0:   c = scene_light0(scene);
            COL_DIFFUSE:  c = rgb555(16, 16, 16);
            COL_AMBIENT:  c = scene_ambient(scene);
            COL_SPECULAR: c = rgb555(20, 20, 20);
            COL_EMISSION: c = scene_emission(scene);
            default:      c = '0;
        endcase
        return c;
    endfunction

    // Light one presets.
    function automatic t_color light_color(input t_light light);
        t_color c;
        case (light)
            2'd0:    c = rgb555(14, 14, 14);
            2'd1:    c = rgb555(20, 20, 20);
            2'd2:    c = rgb555(31, 31, 31);
            default: c = rgb555(8, 8, 8);
        endcase
        return c;
    endfunction

endpackage

@@ hdl/lcf_if.sv @@
// ----------------------------------------------------------------------------
// lcf_if
// Valid/ready channels of the light color fader: the command channel and the
// color result channel.
// ----------------------------------------------------------------------------
interface lcf_in_if;
    logic            valid;
    logic            ready;
    logic [1:0]      opcode;
    lcf_pkg::t_scene scene_index;
    lcf_pkg::t_light light_index;

    modport source (output valid, output opcode, output scene_index,
                    output light_index, input ready);
    modport sink   (input valid, input opcode, input scene_index,
                    input light_index, output ready);
endinterface

interface lcf_out_if;
    logic            valid;
    logic            ready;
    lcf_pkg::t_color light_zero_color;
    lcf_pkg::t_color light_one_color;
    lcf_pkg::t_color diffuse_color;
    lcf_pkg::t_color ambient_color;
    lcf_pkg::t_color specular_color;
    lcf_pkg::t_color emission_color;

    modport source (output valid, output light_zero_color, output light_one_color,
                    output diffuse_color, output ambient_color,
                    output specular_color, output emission_color, input ready);
    modport sink   (input valid, input light_zero_color, input light_one_color,
                    input diffuse_color, input ambient_color,
                    input specular_color, input emission_color, output ready);
endinterface

@@ hdl/lcf_blend.sv @@
// ----------------------------------------------------------------------------
// lcf_blend
// Linear blend of one RGB555 color: each channel becomes
// start + step * (target - start) / FADE_STEPS, truncated toward zero.
// ----------------------------------------------------------------------------
module lcf_blend #(
    parameter  int FADE_STEPS = 60,
    localparam int STEP_W     = $clog2(FADE_STEPS + 1)
) (
    input  lcf_pkg::t_color    i_start,
    input  lcf_pkg::t_color    i_target,
    input  logic [STEP_W-1:0]  i_step,
    output lcf_pkg::t_color    o_color
);
    import lcf_pkg::*;

    // The magnitude step * |target - start| is divided by FADE_STEPS through a
    // reciprocal multiply. With SHIFT = MAG_W + clog2(FADE_STEPS) and the
    // reciprocal rounded up, the quotient is exact for every magnitude.
    localparam int MAG_W   = STEP_W + CHAN_W;
    localparam int SHIFT   = MAG_W + $clog2(FADE_STEPS);
    localparam int RECIP_W = SHIFT + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam logic [PROD_W-1:0] RECIP =
        PROD_W'(((1 << SHIFT) + FADE_STEPS - 1) / FADE_STEPS);

    for (genvar ch = 0; ch < NUM_CHANS; ch++) begin : g_chan
        t_chan              w_a;
        t_chan              w_b;
        logic               w_neg;
        t_chan              w_dmag;
        logic [MAG_W-1:0]   w_mag;
        logic [PROD_W-1:0]  w_prod;
        t_chan              w_quot;

        assign w_a    = i_start[ch*CHAN_W +: CHAN_W];
        assign w_b    = i_target[ch*CHAN_W +: CHAN_W];
        assign w_neg  = (w_b < w_a);
        assign w_dmag = w_neg ? (w_a - w_b) : (w_b - w_a);

        // Scaled distance, then division by the step count.
        assign w_mag  = MAG_W'(i_step) * MAG_W'(w_dmag);
        assign w_prod = PROD_W'(w_mag) * RECIP;
        assign w_quot = w_prod[SHIFT +: CHAN_W];

        // Apply the quotient with the sign of the distance.
        assign o_color[ch*CHAN_W +: CHAN_W] = w_neg ? (w_a - w_quot) : (w_a + w_quot);
    end

endmodule

@@ hdl/rgb555_light_color_fader_core.sv @@
// ----------------------------------------------------------------------------
// rgb555_light_color_fader_core
// Fades six RGB555 colors (two lights and four material colors) linearly
// between preset colors, one step per tick command.
// ----------------------------------------------------------------------------
// The block takes one command per clock cycle while it is not stalled. A
// command is captured in an input register and executed once the result
// register can take a beat, which updates all color state at once; a result
// beat, when the command has one, shows on the result channel the cycle after
// execution. Tick and set commands give a result beat (a tick only when some
// color is still fading); fade commands give none. Commands stall only while
// the result register holds a beat that has not been taken. The fade length is
// FADE_STEPS ticks; each tick runs all eighteen channel blends in parallel.
module rgb555_light_color_fader_core #(
    parameter int FADE_STEPS = 60
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    lcf_in_if.sink  i_item,
    lcf_out_if.source o_result
);
    import lcf_pkg::*;

    localparam int STEP_W = $clog2(FADE_STEPS + 1);
    localparam logic [STEP_W-1:0] STEP_IDLE = STEP_W'(FADE_STEPS);

    // Input register.
    logic    r_in_valid;
    t_opcode r_op;
    t_scene  r_scene;
    t_light  r_light;

    // Color state.
    t_color            r_cur   [NUM_COLORS];
    t_color            r_start [NUM_COLORS];
    t_color            r_tgt   [NUM_COLORS];
    logic [STEP_W-1:0] r_step  [NUM_COLORS];

    t_color            n_cur   [NUM_COLORS];
    t_color            n_start [NUM_COLORS];
    t_color            n_tgt   [NUM_COLORS];
    logic [STEP_W-1:0] n_step  [NUM_COLORS];

    // Result register.
    logic   r_out_valid;
    t_color r_out [NUM_COLORS];

    t_color            w_blend   [NUM_COLORS];
    logic [STEP_W-1:0] w_step_up [NUM_COLORS];
    logic [NUM_COLORS-1:0] w_adv;
    logic   w_go;
    logic   w_has_result;
    t_scene w_scene;

    // The held command executes when the result register can take a beat.
    assign w_go         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_in_valid || w_go;

    // Scenes six and seven use the last scene preset.
    assign w_scene = (r_scene > 3'd5) ? 3'd5 : r_scene;

    // Blend every color at its advanced step.
    for (genvar i = 0; i < NUM_COLORS; i++) begin : g_color
        assign w_adv[i]     = (r_step[i] < STEP_IDLE);
        assign w_step_up[i] = r_step[i] + STEP_W'(1);

        lcf_blend #(
            .FADE_STEPS (FADE_STEPS)
        ) u_blend (
            .i_start  (r_start[i]),
            .i_target (r_tgt[i]),
            .i_step   (w_step_up[i]),
            .o_color  (w_blend[i])
        );
    end

    assign w_has_result = ((r_op == OP_TICK) && (|w_adv)) || (r_op == OP_SET);

    // Next color state for the held command.
    always_comb begin
        for (int i = 0; i < NUM_COLORS; i++) begin
            n_cur[i]   = r_cur[i];
            n_start[i] = r_start[i];
            n_tgt[i]   = r_tgt[i];
            n_step[i]  = r_step[i];
            case (r_op)
                OP_TICK: begin
                    if (w_adv[i]) begin
                        n_step[i] = w_step_up[i];
                        n_cur[i]  = w_blend[i];
                    end
                end
                OP_SET: begin
                    n_step[i] = STEP_IDLE;
                    if (i == int'(COL_LIGHT1)) begin
                        n_cur[i] = light_color(r_light);
                    end else begin
                        n_cur[i] = scene_color(w_scene, t_slot'(i));
                    end
                end
                OP_FADE_SCENE: begin
                    if (i != int'(COL_LIGHT1)) begin
                        n_start[i] = r_cur[i];
                        n_tgt[i]   = scene_color(w_scene, t_slot'(i));
                        n_step[i]  = '0;
                    end
                end
                OP_FADE_LIGHT: begin
                    if (i == int'(COL_LIGHT1)) begin
                        n_start[i] = r_cur[i];
                        n_tgt[i]   = light_color(r_light);
                        n_step[i]  = '0;
                    end
                end
                default: begin
                    n_step[i] = r_step[i];
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
        if (i_item.ready && i_item.valid) begin
            r_op    <= t_opcode'(i_item.opcode);
            r_scene <= i_item.scene_index;
            r_light <= i_item.light_index;
        end
    end

    // Color state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COLORS; i++) begin
                r_cur[i]   <= '0;
                r_start[i] <= '0;
                r_tgt[i]   <= '0;
                r_step[i]  <= STEP_IDLE;
            end
        end else if (w_go) begin
            for (int i = 0; i < NUM_COLORS; i++) begin
                r_cur[i]   <= n_cur[i];
                r_start[i] <= n_start[i];
                r_tgt[i]   <= n_tgt[i];
                r_step[i]  <= n_step[i];
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_go && w_has_result) begin
            for (int i = 0; i < NUM_COLORS; i++) begin
                r_out[i] <= n_cur[i];
            end
        end
    end

    assign o_result.valid            = r_out_valid;
    assign o_result.light_zero_color = r_out[COL_LIGHT0];
    assign o_result.light_one_color  = r_out[COL_LIGHT1];
    assign o_result.diffuse_color    = r_out[COL_DIFFUSE];
    assign o_result.ambient_color    = r_out[COL_AMBIENT];
    assign o_result.specular_color   = r_out[COL_SPECULAR];
    assign o_result.emission_color   = r_out[COL_EMISSION];

`ifndef ASSERT_OFF
    // No step counter ever runs past the idle value.
    a_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step[0] <= STEP_IDLE) && (r_step[1] <= STEP_IDLE) &&
        (r_step[2] <= STEP_IDLE) && (r_step[3] <= STEP_IDLE) &&
        (r_step[4] <= STEP_IDLE) && (r_step[5] <= STEP_IDLE))
        else $error("step counter beyond fade length");

    // An executed command with a result always leaves a beat pending.
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && w_has_result |=> r_out_valid)
        else $error("result beat lost");

    // A set command leaves every color idle.
    a_set_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_go && (r_op == OP_SET) |=> !(|w_adv))
        else $error("color still fading after set");

    // Commands are refused only while one is held and stalled.
    a_stall_reason: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_item.ready |-> r_in_valid && r_out_valid && !o_result.ready)
        else $error("command refused without a stall");
`endif

endmodule
